>>> rtl/core/aop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_pkg
// Shared constants and types of the antithetic option payoff pair.
// ----------------------------------------------------------------------------
package aop_pkg;

	localparam int EXP_ARG_W = 56;
	localparam int KW = 7;
	localparam int UXW = 39;
	localparam int RECIP_SHIFT = 40;
	localparam int K_OFFSET = 47;
	localparam int OUT_SHIFT = 46;
	localparam int TAYLOR_TERMS = 20;
	localparam longint EXP_LIMIT = 64'sd137438953472;
	localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
	localparam logic [8:0] LN2_RECIP = 9'((64'd1 << RECIP_SHIFT) / 64'(LN2_Q32));

	localparam logic [2:0] REG_SPOT = 3'd0;
	localparam logic [2:0] REG_STRIKE = 3'd1;
	localparam logic [2:0] REG_RATE = 3'd2;
	localparam logic [2:0] REG_VOL = 3'd3;
	localparam logic [2:0] REG_EXPIRY = 3'd4;
	localparam logic [2:0] REG_PUT = 3'd5;

	typedef struct packed {
		logic valid;
		logic last;
	} aop_ctl_t;

	typedef struct packed {
		logic [31:0]   frac;
		logic [KW-1:0] kexp;
		logic          zero;
		logic [62:0]   term;
		logic [63:0]   acc;
	} aop_tay_t;

endpackage

>>> rtl/core/aop_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_term
// One series term: next = floor(term * f / 2^62) / n, added to the sum.
// ----------------------------------------------------------------------------
module aop_term import aop_pkg::*; #(
	parameter int TERM_IDX = 1
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  aop_ctl_t ctl_in,
	input  aop_tay_t tay_in,
	output aop_ctl_t ctl_out,
	output aop_tay_t tay_out
);

	localparam logic [62:0] RECIP = 63'((64'd1 << 62) / 64'(TERM_IDX));
	localparam logic [61:0] DIVISOR = 62'(TERM_IDX);

	aop_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	aop_tay_t tay_s1, tay_s2, tay_s3, tay_s4, tay_s5;

	logic [63:0] p00_s1;
	logic [61:0] p01_s1;
	logic [62:0] p10_s1;
	logic [60:0] p11_s1;
	logic [61:0] x_s2, x_s3, x_s4;
	logic [63:0] r00_s3;
	logic [62:0] r01_s3;
	logic [61:0] r10_s3;
	logic [60:0] r11_s3;
	logic [61:0] q0_s4;

	logic [31:0]  f_lo;
	logic [29:0]  f_hi;
	logic [124:0] prod_a;
	logic [124:0] prod_b;
	logic [61:0]  rem;
	logic [61:0]  q_fix;

	always_comb begin
		f_lo = {tay_in.frac[1:0], 30'b0};
		f_hi = tay_in.frac[31:2];
		prod_a = {61'b0, p00_s1} + {31'b0, p01_s1, 32'b0} + {30'b0, p10_s1, 32'b0}
			+ {p11_s1, 64'b0};
		prod_b = {61'b0, r00_s3} + {30'b0, r01_s3, 32'b0} + {31'b0, r10_s3, 32'b0}
			+ {r11_s3, 64'b0};
		rem = x_s4 - 62'(q0_s4 * DIVISOR);
		q_fix = q0_s4 + 62'(rem >= DIVISOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= tay_in.term[31:0] * f_lo;
			p01_s1 <= tay_in.term[31:0] * f_hi;
			p10_s1 <= tay_in.term[62:32] * f_lo;
			p11_s1 <= tay_in.term[62:32] * f_hi;
			tay_s1 <= tay_in;

			x_s2 <= prod_a[123:62];
			tay_s2 <= tay_s1;

			r00_s3 <= x_s2[31:0] * RECIP[31:0];
			r01_s3 <= x_s2[31:0] * RECIP[62:32];
			r10_s3 <= x_s2[61:32] * RECIP[31:0];
			r11_s3 <= x_s2[61:32] * RECIP[62:32];
			x_s3 <= x_s2;
			tay_s3 <= tay_s2;

			q0_s4 <= prod_b[123:62];
			x_s4 <= x_s3;
			tay_s4 <= tay_s3;

			tay_s5.frac <= tay_s4.frac;
			tay_s5.kexp <= tay_s4.kexp;
			tay_s5.zero <= tay_s4.zero;
			tay_s5.term <= {1'b0, q_fix};
			tay_s5.acc <= tay_s4.acc + {2'b0, q_fix};
		end
	end

	assign ctl_out = ctl_s5;
	assign tay_out = tay_s5;

endmodule

>>> rtl/core/aop_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_exp
// Pipelined exp of a signed Q24.32 argument, unsigned Q48.16 result.
// ----------------------------------------------------------------------------
module aop_exp import aop_pkg::*; #(
	parameter int TERMS = TAYLOR_TERMS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  aop_ctl_t                    ctl_in,
	input  logic signed [EXP_ARG_W-1:0] arg,
	output aop_ctl_t                    ctl_out,
	output logic [63:0]                 result
);

	localparam logic signed [EXP_ARG_W-1:0] LIM = EXP_ARG_W'(EXP_LIMIT);
	localparam logic signed [EXP_ARG_W-1:0] LIM_NEG = -LIM;
	localparam logic signed [EXP_ARG_W-1:0] BIAS =
		EXP_ARG_W'(longint'(K_OFFSET) * longint'(LN2_Q32));
	localparam logic [KW-1:0] SHIFT_BASE = KW'(OUT_SHIFT + K_OFFSET);

	aop_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [UXW-1:0] ux_s1, ux_s2;
	logic zero_s1, zero_s2, zero_s3;
	logic [UXW+8:0] kprod_s2;
	logic [32:0] rem_s3;
	logic [KW-1:0] kq_s3;
	aop_tay_t tay_s4;
	logic [63:0] rnd_s5;
	logic [5:0] sh_s5;
	logic kill_s5;
	logic [63:0] res_s6;

	aop_tay_t tay_chain [TERMS+1];
	aop_ctl_t ctl_chain [TERMS+1];

	logic signed [EXP_ARG_W-1:0] xc;
	logic signed [EXP_ARG_W-1:0] ux_c;
	logic zero_c;
	logic [KW-1:0] kq_c;
	logic [UXW-1:0] rem_c;
	aop_tay_t tay_c;
	aop_tay_t tay_end;
	logic [KW-1:0] sh_c;

	always_comb begin
		zero_c = (arg <= LIM_NEG);
		xc = (arg >= LIM) ? LIM - EXP_ARG_W'(1) : arg;
		ux_c = xc + BIAS;
		kq_c = kprod_s2[RECIP_SHIFT +: KW];
		rem_c = ux_s2 - (UXW'(kq_c) * UXW'(LN2_Q32));
		tay_c.zero = zero_s3;
		tay_c.term = 63'(1) << 62;
		tay_c.acc = 64'(1) << 62;
		if (rem_s3 >= {1'b0, LN2_Q32}) begin
			tay_c.kexp = kq_s3 + KW'(1);
			tay_c.frac = 32'(rem_s3 - {1'b0, LN2_Q32});
		end else begin
			tay_c.kexp = kq_s3;
			tay_c.frac = rem_s3[31:0];
		end
		tay_end = tay_chain[TERMS];
		sh_c = SHIFT_BASE - tay_end.kexp;
	end

	assign tay_chain[0] = tay_s4;
	assign ctl_chain[0] = ctl_s4;

	for (genvar i = 0; i < TERMS; i++) begin : g_term
		aop_term #(.TERM_IDX(i + 1)) u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_chain[i]),
			.tay_in  (tay_chain[i]),
			.ctl_out (ctl_chain[i+1]),
			.tay_out (tay_chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_chain[TERMS];
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= zero_c ? '0 : UXW'(ux_c);
			zero_s1 <= zero_c;

			kprod_s2 <= ux_s1 * LN2_RECIP;
			ux_s2 <= ux_s1;
			zero_s2 <= zero_s1;

			kq_s3 <= kq_c;
			rem_s3 <= rem_c[32:0];
			zero_s3 <= zero_s2;

			tay_s4 <= tay_c;

			kill_s5 <= tay_end.zero || (sh_c >= KW'(64));
			sh_s5 <= sh_c[5:0];
			rnd_s5 <= tay_end.acc + ((sh_c == '0) ? 64'd0 : (64'd1 << (sh_c[5:0] - 6'd1)));

			res_s6 <= kill_s5 ? 64'd0 : (rnd_s5 >> sh_s5);
		end
	end

	assign ctl_out = ctl_s6;
	assign result = res_s6;

endmodule

>>> rtl/core/antithetic_option_payoff_pair.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antithetic_option_payoff_pair
// Discounted call or put payoffs of the two antithetic Black-Scholes paths.
//
//   channel  signals                                              direction
//   input    in_valid/in_ready, normal_sample, last_pair          in
//   output   out_valid/out_ready, payoff_plus/minus, batch_end    out
//   config   cfg_write, cfg_index, cfg_data                       in, no wait
//
// One sample is taken every cycle while the skid register is empty; each exp
// unit chains twenty five-stage series terms.
// Reset clears all valid bits and loads the register defaults.
// A stalled output parks one result in a skid register; the pipeline
// freezes only while that register is full, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module antithetic_option_payoff_pair import aop_pkg::*; #(
	parameter int TERMS = TAYLOR_TERMS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] normal_sample,
	input  logic               last_pair,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        payoff_plus,
	output logic [31:0]        payoff_minus,
	output logic               batch_end,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [31:0] spot_q, strike_q;
	logic signed [18:0] rate_q;
	logic [19:0] vol_q;
	logic [20:0] expiry_q;
	logic put_q;

	logic en;

	aop_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [39:0] vv_s1;
	logic signed [52:0] shock_s1, shock_s2, shock_s3;
	logic signed [40:0] rt_s1;
	logic signed [40:0] drift_s2;
	logic signed [41:0] disc_s2, disc_s3;
	logic signed [62:0] dt_s3;
	logic signed [EXP_ARG_W-1:0] arg_s4 [2];
	logic signed [EXP_ARG_W-1:0] darg_s4;

	aop_ctl_t ctl_x;
	logic [63:0] exp_x [2];
	logic [63:0] disc_x;

	aop_ctl_t ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;
	logic [63:0] d_s5, d_s6, d_s7;
	logic [63:0] sp_lo_s5 [2];
	logic [63:0] sp_hi_s5 [2];
	logic [63:0] price_s6 [2];
	logic [63:0] diff_s7 [2];
	logic [63:0] m00_s8 [2];
	logic [63:0] m01_s8 [2];
	logic [63:0] m10_s8 [2];
	logic [63:0] m11_s8 [2];
	logic [31:0] pay_s9 [2];

	logic out_v_q, skid_v_q;
	logic [31:0] out_plus_q, out_minus_q, skid_plus_q, skid_minus_q;
	logic out_last_q, skid_last_q;
	logic take_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spot_q <= 32'd6553600;
			strike_q <= 32'd6553600;
			rate_q <= 19'sd3277;
			vol_q <= 20'd13107;
			expiry_q <= 21'd65536;
			put_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SPOT: spot_q <= cfg_data;
				REG_STRIKE: strike_q <= cfg_data;
				REG_RATE: rate_q <= cfg_data[18:0];
				REG_VOL: vol_q <= cfg_data[19:0];
				REG_EXPIRY: expiry_q <= cfg_data[20:0];
				REG_PUT: put_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en = !skid_v_q;
	assign in_ready = en;

	// exponent arguments
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.last <= last_pair;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vv_s1 <= vol_q * vol_q;
			shock_s1 <= $signed({1'b0, vol_q}) * normal_sample;
			rt_s1 <= rate_q * $signed({1'b0, expiry_q});

			drift_s2 <= $signed({{6{rate_q[18]}}, rate_q, 16'b0}) - $signed({2'b0, vv_s1[39:1]});
			disc_s2 <= -$signed({rt_s1[40], rt_s1});
			shock_s2 <= shock_s1;

			dt_s3 <= drift_s2 * $signed({1'b0, expiry_q});
			disc_s3 <= disc_s2;
			shock_s3 <= shock_s2;

			arg_s4[0] <= EXP_ARG_W'(dt_s3 >>> 16) + EXP_ARG_W'(shock_s3);
			arg_s4[1] <= EXP_ARG_W'(dt_s3 >>> 16) - EXP_ARG_W'(shock_s3);
			darg_s4 <= EXP_ARG_W'(disc_s3);
		end
	end

	aop_exp #(.TERMS(TERMS)) u_exp_plus (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s4),
		.arg     (arg_s4[0]),
		.ctl_out (ctl_x),
		.result  (exp_x[0])
	);

	aop_exp #(.TERMS(TERMS)) u_exp_minus (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s4),
		.arg     (arg_s4[1]),
		.ctl_out (),
		.result  (exp_x[1])
	);

	aop_exp #(.TERMS(TERMS)) u_exp_disc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s4),
		.arg     (darg_s4),
		.ctl_out (),
		.result  (disc_x)
	);

	// prices and payoffs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else if (en) begin
			ctl_s5 <= ctl_x;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s5 <= disc_x;
			d_s6 <= d_s5;
			d_s7 <= d_s6;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [96:0] price_c;
		logic [127:0] pay_c;

		always_comb begin
			price_c = {33'b0, sp_lo_s5[l]} + {1'b0, sp_hi_s5[l], 32'b0} + 97'h8000;
			pay_c = {64'b0, m00_s8[l]} + {32'b0, m01_s8[l], 32'b0}
				+ {32'b0, m10_s8[l], 32'b0} + {m11_s8[l], 64'b0} + 128'h8000;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sp_lo_s5[l] <= spot_q * exp_x[l][31:0];
				sp_hi_s5[l] <= spot_q * exp_x[l][63:32];

				price_s6[l] <= (|price_c[96:80]) ? '1 : price_c[79:16];

				if (put_q) begin
					diff_s7[l] <= ({32'b0, strike_q} > price_s6[l]) ?
						{32'b0, strike_q} - price_s6[l] : 64'd0;
				end else begin
					diff_s7[l] <= (price_s6[l] > {32'b0, strike_q}) ?
						price_s6[l] - {32'b0, strike_q} : 64'd0;
				end

				m00_s8[l] <= diff_s7[l][31:0] * d_s7[31:0];
				m01_s8[l] <= diff_s7[l][31:0] * d_s7[63:32];
				m10_s8[l] <= diff_s7[l][63:32] * d_s7[31:0];
				m11_s8[l] <= diff_s7[l][63:32] * d_s7[63:32];

				pay_s9[l] <= (|pay_c[127:48]) ? 32'hFFFFFFFF : pay_c[47:16];
			end
		end
	end

	// output register with skid
	assign take_out = out_ready || !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take_out) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= ctl_s9.valid;
			end
		end else if (en && ctl_s9.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			if (skid_v_q) begin
				out_plus_q <= skid_plus_q;
				out_minus_q <= skid_minus_q;
				out_last_q <= skid_last_q;
			end else begin
				out_plus_q <= pay_s9[0];
				out_minus_q <= pay_s9[1];
				out_last_q <= ctl_s9.last;
			end
		end else if (en) begin
			skid_plus_q <= pay_s9[0];
			skid_minus_q <= pay_s9[1];
			skid_last_q <= ctl_s9.last;
		end
	end

	assign out_valid = out_v_q;
	assign payoff_plus = out_plus_q;
	assign payoff_minus = out_minus_q;
	assign batch_end = out_last_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the antithetic option payoff pair against a bit-exact fixed-point
// price model kept in the bench. Samples are sent through a queue-fed driver
// over several register settings (defaults, extremes and random markets).
// Each phase runs with one of four idle and stall patterns. A monitor compares
// every output transfer with the oldest predicted payoff pair.
// ----------------------------------------------------------------------------
module tb import aop_pkg::*; ();

	localparam longint LN2_FX = 64'sd2977044472;
	localparam longint EXP_CLAMP = 64'sd137438953472;
	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam int PHASE_ITEMS = 200;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic signed [31:0] z;
		logic               last;
	} sample_t;

	typedef struct packed {
		logic [31:0] plus;
		logic [31:0] minus;
		logic        last;
	} payoff_pair_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] normal_sample = '0;
	logic               last_pair = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [31:0]        payoff_plus;
	logic [31:0]        payoff_minus;
	logic               batch_end;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	logic [31:0] spot_m = 32'd6553600;
	logic [31:0] strike_m = 32'd6553600;
	logic [18:0] rate_m = 19'd3277;
	logic [19:0] vol_m = 20'd13107;
	logic [20:0] expiry_m = 21'd65536;
	logic        put_m = 1'b0;

	sample_t      sample_q[$];
	payoff_pair_t payoff_q[$];
	logic         in_taken = 1'b0;
	int           send_idle = 0;
	int           stall = 0;
	int           errors = 0;

	antithetic_option_payoff_pair dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.normal_sample(normal_sample), .last_pair(last_pair),
		.out_valid(out_valid), .out_ready(out_ready),
		.payoff_plus(payoff_plus), .payoff_minus(payoff_minus), .batch_end(batch_end),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [63:0] q16_mul_round(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b} + 128'h8000;
		if (prod[127:80] != '0)
			return '1;
		return prod[79:16];
	endfunction

	function automatic logic [63:0] exp_q16(longint x);
		longint       k;
		longint       f;
		logic [63:0]  f62;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [127:0] prod;
		int           s;
		if (x <= -EXP_CLAMP)
			return '0;
		if (x >= EXP_CLAMP)
			x = EXP_CLAMP - 1;
		if (x >= 0)
			k = x / LN2_FX;
		else
			k = -((-x + LN2_FX - 1) / LN2_FX);
		f = x - k * LN2_FX;
		f62 = 64'(f) << 30;
		term = 64'd1 << 62;
		sum = term;
		for (int n = 1; n <= 20; n++) begin
			prod = {64'd0, term} * {64'd0, f62};
			term = prod[125:62] / 64'(n);
			sum = sum + term;
		end
		s = 46 - int'(k);
		if (s == 0)
			return sum;
		if (s >= 64)
			return '0;
		return (sum + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic logic [31:0] path_payoff(longint expo, logic [63:0] disc);
		logic [63:0] price;
		logic [63:0] gain;
		logic [63:0] v;
		price = q16_mul_round(64'(spot_m), exp_q16(expo));
		if (put_m)
			gain = (64'(strike_m) > price) ? 64'(strike_m) - price : 64'd0;
		else
			gain = (price > 64'(strike_m)) ? price - 64'(strike_m) : 64'd0;
		v = q16_mul_round(gain, disc);
		return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
	endfunction

	function automatic payoff_pair_t price_pair(logic signed [31:0] z, logic last);
		longint       r;
		longint       vol;
		longint       t;
		longint       drift;
		longint       base;
		longint       shock;
		logic [63:0]  disc;
		payoff_pair_t res;
		r = longint'($signed(rate_m));
		vol = longint'({1'b0, vol_m});
		t = longint'({1'b0, expiry_m});
		drift = r * 65536 - longint'((64'(vol_m) * 64'(vol_m)) >> 1);
		base = (drift * t) >>> 16;
		shock = vol * longint'(z);
		disc = exp_q16(-(r * t));
		res.plus = path_payoff(base + shock, disc);
		res.minus = path_payoff(base - shock, disc);
		res.last = last;
		return res;
	endfunction

	always @(posedge clk) begin
		payoff_pair_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				payoff_q.push_back(price_pair(normal_sample, last_pair));
				in_taken <= 1'b1;
			end
			if (out_valid && out_ready) begin
				if (payoff_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected transfer: %h %h %b",
							payoff_plus, payoff_minus, batch_end);
				end else begin
					want = payoff_q.pop_front();
					if (want.plus !== payoff_plus || want.minus !== payoff_minus ||
							want.last !== batch_end) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %h %h %b got %h %h %b",
								want.plus, want.minus, want.last,
								payoff_plus, payoff_minus, batch_end);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		sample_t s;
		if (!in_valid || in_taken) begin
			if (arst_n && sample_q.size() > 0 && $urandom_range(99, 0) >= send_idle) begin
				s = sample_q.pop_front();
				normal_sample <= s.z;
				last_pair <= s.last;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		in_taken <= 1'b0;
		out_ready <= ($urandom_range(99, 0) >= stall);
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		case (idx)
			REG_SPOT:   spot_m = value;
			REG_STRIKE: strike_m = value;
			REG_RATE:   rate_m = value[18:0];
			REG_VOL:    vol_m = value[19:0];
			REG_EXPIRY: expiry_m = value[20:0];
			REG_PUT:    put_m = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic set_market(logic [31:0] spot, logic [31:0] strike, logic [31:0] rate,
			logic [31:0] vol, logic [31:0] expiry, logic [31:0] put);
		// upper bits random to exercise masking
		write_reg(REG_SPOT, spot);
		write_reg(REG_STRIKE, strike);
		write_reg(REG_RATE, {13'($urandom_range(8191, 0)), rate[18:0]});
		write_reg(REG_VOL, {12'($urandom_range(4095, 0)), vol[19:0]});
		write_reg(REG_EXPIRY, {11'($urandom_range(2047, 0)), expiry[20:0]});
		write_reg(REG_PUT, {31'($urandom), put[0]});
		write_reg(REG_UNUSED + 3'($urandom_range(1, 0)), $urandom);
	endtask

	task automatic wait_idle();
		while (sample_q.size() != 0 || in_valid || payoff_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		sample_t s;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9, 0))
				0:       s.z = $urandom;
				1:       s.z = $signed($urandom_range(1048575, 0)) - 524288;
				default: s.z = $signed($urandom_range(393216, 0)) - 196608;
			endcase
			s.last = ($urandom_range(7, 0) == 0);
			sample_q.push_back(s);
		end
	endtask

	task automatic queue_directed();
		logic signed [31:0] zs[12];
		sample_t s;
		zs = '{32'sd0, 32'sd1, -32'sd1, 32'sd65536, -32'sd65536, 32'sd131072,
			-32'sd196608, 32'sh7FFFFFFF, 32'sh80000000, 32'sh55555555,
			32'shAAAAAAAA, 32'sd12345};
		foreach (zs[i]) begin
			s.z = zs[i];
			s.last = i[0];
			sample_q.push_back(s);
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset defaults
		queue_directed();
		wait_idle();

		for (int ph = 0; ph < 14; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  stall = 0;  end
				1: begin send_idle = 45; stall = 0;  end
				2: begin send_idle = 0;  stall = 45; end
				default: begin send_idle = 36; stall = 36; end
			endcase
			case (ph)
				0: set_market(32'd0, 32'd6553600, 32'h20000, 32'd0, 32'd0, 32'd1);
				1: set_market(32'hFFFFFFFF, 32'd0, 32'h1FFFF, 32'hFFFFF, 32'h1FFFFF, 32'd0);
				2: set_market(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h20000, 32'hFFFFF,
					32'h1FFFFF, 32'd1);
				3: set_market(32'd6553600, 32'd6553600, 32'h7FFFF, 32'd65536, 32'd65536,
					32'd0);
				4: set_market(32'd1, 32'hFFFFFFFF, 32'd0, 32'd1, 32'd1, 32'd1);
				default: set_market($urandom_range(13107200, 3276800),
					$urandom_range(13107200, 3276800),
					32'($signed($urandom_range(13107, 0)) - 6553),
					$urandom_range(65536, 3277), $urandom_range(327680, 0),
					$urandom_range(1, 0));
			endcase
			if (ph < 5)
				queue_directed();
			queue_random(ph < 5 ? 40 : PHASE_ITEMS);
			wait_idle();
		end

		if (errors == 0 && payoff_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/core/aop_pkg.sv
rtl/core/aop_term.sv
rtl/core/aop_exp.sv
rtl/core/antithetic_option_payoff_pair.sv
sim/tb.sv
